>>> rtl/core/vtct_pkg.sv
package vtct_pkg;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 8;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Reset values of the matrix registers: identity at sixteen fraction bits.
    localparam logic [NUM_REGS-1:0][63:0] MAT_RESET = '{
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000
    };

    typedef logic [NUM_REGS-1:0][63:0] mat_t;
    typedef logic signed [3:0][31:0] hvec_t;

    typedef struct packed {
        hvec_t clip;
        logic  wz;
        logic  vis;
    } side_t;

endpackage

>>> rtl/core/vtct_xform.sv
module vtct_xform
    import vtct_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               en,
    input  mat_t               mat,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    output hvec_t              h_reg
);

    localparam int SW = 67;

    logic signed [63:0] prod_reg [4][3];
    logic signed [31:0] trans_reg [4];
    hvec_t              h_next;

    function automatic logic signed [31:0] coef(input mat_t m, input int col, input int row);
        logic [63:0] r;
        r = m[2*col + row/2];
        return (row % 2 == 1) ? r[63:32] : r[31:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                prod_reg[r][0] <= coef(mat, 0, r) * px;
                prod_reg[r][1] <= coef(mat, 1, r) * py;
                prod_reg[r][2] <= coef(mat, 2, r) * pz;
                trans_reg[r]   <= coef(mat, 3, r);
            end
        end
    end

    always_comb begin
        logic signed [SW-1:0] tot;
        logic signed [SW-1:0] sh;
        for (int r = 0; r < 4; r++) begin
            tot = (SW'(trans_reg[r]) <<< FRAC_BITS)
                + SW'(prod_reg[r][0]) + SW'(prod_reg[r][1]) + SW'(prod_reg[r][2])
                + (SW'(1) <<< (FRAC_BITS - 1));
            sh = tot >>> FRAC_BITS;
            if (sh > SW'(S32_MAX)) begin
                h_next[r] = S32_MAX;
            end else if (sh < SW'(S32_MIN)) begin
                h_next[r] = S32_MIN;
            end else begin
                h_next[r] = sh[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_reg <= h_next;
        end
    end

endmodule

>>> rtl/core/vtct_div.sv
module vtct_div
    import vtct_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    input  logic               bypass,
    output logic signed [31:0] q_reg
);

    localparam int NW = 32 + FRAC_BITS;

    // Restoring division, one quotient bit per stage. The numerator shifts
    // out of the top of nq while quotient bits shift in at the bottom.
    logic [31:0]        rem_reg [NW+1];
    logic [NW-1:0]      nq_reg  [NW+1];
    logic [31:0]        d_reg   [NW+1];
    logic               neg_reg [NW+1];
    logic               byp_reg [NW+1];
    logic signed [31:0] a_reg   [NW+1];

    logic [31:0] abs_a;
    logic [31:0] abs_b;

    assign abs_a = a[31] ? 32'(-a) : 32'(a);
    assign abs_b = b[31] ? 32'(-b) : 32'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            nq_reg[0]  <= {abs_a, FRAC_BITS'(0)};
            d_reg[0]   <= abs_b;
            neg_reg[0] <= a[31] ^ b[31];
            byp_reg[0] <= bypass;
            a_reg[0]   <= a;
        end
    end

    for (genvar s = 1; s <= NW; s++) begin : g_step
        logic [32:0] t;
        logic        ge;
        assign t  = {rem_reg[s-1], nq_reg[s-1][NW-1]};
        assign ge = t >= {1'b0, d_reg[s-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= ge ? 32'(t - {1'b0, d_reg[s-1]}) : t[31:0];
                nq_reg[s]  <= {nq_reg[s-1][NW-2:0], ge};
                d_reg[s]   <= d_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                byp_reg[s] <= byp_reg[s-1];
                a_reg[s]   <= a_reg[s-1];
            end
        end
    end

    logic [NW:0]        qr;
    logic signed [31:0] q_next;

    always_comb begin
        qr = {1'b0, nq_reg[NW]};
        if ({rem_reg[NW], 1'b0} >= {1'b0, d_reg[NW]}) begin
            qr = qr + 1'b1;
        end
        if (byp_reg[NW]) begin
            q_next = a_reg[NW];
        end else if (neg_reg[NW]) begin
            q_next = (qr > (NW+1)'(33'h0_8000_0000)) ? S32_MIN : 32'(-qr);
        end else begin
            q_next = (qr > (NW+1)'(33'h0_7FFF_FFFF)) ? S32_MAX : qr[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

endmodule

>>> rtl/core/vertex_transform_clip_test_top.sv
// Channel  Direction  Word
// s_       in         tdata: point_x, point_y, point_z
// m_       out        tdata: clip_x..clip_w, proj_x..proj_z; tuser: w_zero, visible
// cfg_     in         cfg_index, cfg_data (matrix register write)
//
// One word enters per cycle while the output is not stalled; the pipeline depth is set
// by the bit-per-stage divider lanes after the two multiply and sum stages.
// Reset is synchronous and empties the pipeline; the matrix returns to identity.
// A stall at the output freezes every stage together, so nothing is lost or repeated.
module vertex_transform_clip_test_top
    import vtct_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [95:0]          s_tdata,   // point_x, point_y, point_z
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [223:0]         m_tdata,   // clip_x, clip_y, clip_z, clip_w, proj_x, proj_y, proj_z
    output logic [1:0]           m_tuser,   // w_zero, visible
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam int  DIV_LAT  = 32 + FRAC_BITS + 2;
    localparam int  LAT      = DIV_LAT + 2;
    localparam longint DIV_EPS = (64'sd1 << FRAC_BITS) / 1000000;
    localparam longint VIS_EPS = (64'sd1 << FRAC_BITS) / 10000;

    mat_t             mat_reg;
    logic [LAT-1:0]   vld_reg;
    logic             en;
    hvec_t            h;
    side_t            side_reg [DIV_LAT];
    side_t            side_next;
    logic signed [31:0] proj [3];

    assign cfg_ready = 1'b1;
    assign en        = !vld_reg[LAT-1] || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg <= MAT_RESET;
        end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
            mat_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    vtct_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
        .aclk  (aclk),
        .en    (en),
        .mat   (mat_reg),
        .px    (s_tdata[31:0]),
        .py    (s_tdata[63:32]),
        .pz    (s_tdata[95:64]),
        .h_reg (h)
    );

    // A single element of the packed vector is unsigned, so it is made signed
    // before it is widened.
    always_comb begin
        logic signed [35:0] w;
        logic signed [35:0] ax;
        logic signed [35:0] ay;
        logic signed [35:0] az;
        w  = 36'(signed'(h[3]));
        ax = h[0][31] ? -36'(signed'(h[0])) : 36'(signed'(h[0]));
        ay = h[1][31] ? -36'(signed'(h[1])) : 36'(signed'(h[1]));
        az = h[2][31] ? -36'(signed'(h[2])) : 36'(signed'(h[2]));
        side_next.clip = h;
        side_next.wz   = (h[3][31] ? -w : w) <= 36'(DIV_EPS);
        side_next.vis  = (w > 36'(VIS_EPS))
                      && (2 * az <= 3 * w)
                      && (4 * ax <= 5 * w)
                      && (4 * ay <= 5 * w);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < DIV_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_div
        vtct_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .aclk   (aclk),
            .en     (en),
            .a      (h[k]),
            .b      (h[3]),
            .bypass (side_next.wz),
            .q_reg  (proj[k])
        );
    end

    assign m_tdata = {proj[2], proj[1], proj[0], side_reg[DIV_LAT-1].clip[3],
                      side_reg[DIV_LAT-1].clip[2], side_reg[DIV_LAT-1].clip[1],
                      side_reg[DIV_LAT-1].clip[0]};
    assign m_tuser = {side_reg[DIV_LAT-1].vis, side_reg[DIV_LAT-1].wz};

endmodule

>>> rtl/core/vtct_check.sv
module vtct_check (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [223:0] m_tdata,
    input logic [1:0]   m_tuser
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word valid straight after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input blocked although output is free");

    a_bypass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[223:128] == m_tdata[95:0])
        else $error("skipped divide did not pass coordinates through");

    a_vis_w: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tdata[127] && m_tdata[127:96] != 32'd0)
        else $error("visible word with non-positive w");

endmodule

bind vertex_transform_clip_test_top vtct_check u_vtct_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/vertex_transform_clip_test_top_tb.sv
`timescale 1ns / 100ps

module vertex_transform_clip_test_top_tb;
    import vtct_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 36 + FRAC;
    localparam int RANDOM_POINTS = 950;
    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam longint ONE_Q = 64'sd1 << FRAC;
    localparam longint DIV_EPS = ONE_Q / 1000000;
    localparam longint VIS_EPS = ONE_Q / 10000;
    localparam logic [CFG_IDX_W-1:0] REG_C0R01 = 0, REG_C0R23 = 1, REG_C1R01 = 2,
        REG_C1R23 = 3, REG_C2R01 = 4, REG_C2R23 = 5, REG_C3R01 = 6, REG_C3R23 = 7,
        REG_NONE = 8;

    typedef struct packed {
        logic [31:0] cx, cy, cz, cw, px, py, pz;
        logic        wz, vis;
    } vertex_out_t;

    typedef struct {
        logic [31:0] x, y, z;
        logic        known;
        vertex_out_t want;
    } point_row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [223:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    logic [63:0] matrix [NUM_REGS];
    vertex_out_t pending_vertices [$];
    int mismatches = 0;
    int words_out = 0;
    int visible_seen = 0;
    int wzero_seen = 0;
    longint cycles = 0;

    vertex_transform_clip_test_top #(.FRAC_BITS(FRAC)) dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic longint coef(int col, int row);
        logic [63:0] r;
        r = matrix[2 * col + row / 2];
        return (row % 2) ? longint'(signed'(r[63:32])) : longint'(signed'(r[31:0]));
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Products are split into a floored high part and summed fraction bits,
    // so the one rounding is exact even where the full sum would not fit.
    function automatic longint row_dot(int row, longint p [3]);
        longint hi, prod;
        longint lo;
        hi = coef(3, row);
        lo = ONE_Q / 2;
        for (int c = 0; c < 3; c++) begin
            prod = coef(c, row) * p[c];
            hi += prod >>> FRAC;
            lo += prod & (ONE_Q - 1);
        end
        return clamp32(hi + (lo >>> FRAC));
    endfunction

    function automatic longint divide_round(longint a, longint b);
        longint n, d, q, r;
        bit neg;
        n = a * ONE_Q;
        neg = (n < 0) != (b < 0);
        if (n < 0) n = -n;
        d = (b < 0) ? -b : b;
        q = n / d;
        r = n % d;
        if (2 * r >= d) q++;
        return clamp32(neg ? -q : q);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic vertex_out_t transform_vertex(logic [31:0] x, logic [31:0] y,
                                                     logic [31:0] z);
        longint p [3];
        longint h [4];
        longint pr [3];
        vertex_out_t o;
        p[0] = longint'(signed'(x));
        p[1] = longint'(signed'(y));
        p[2] = longint'(signed'(z));
        for (int i = 0; i < 4; i++) h[i] = row_dot(i, p);
        o.wz = mag(h[3]) <= DIV_EPS;
        for (int i = 0; i < 3; i++) pr[i] = o.wz ? h[i] : divide_round(h[i], h[3]);
        o.vis = h[3] > VIS_EPS && 2 * mag(h[2]) <= 3 * h[3]
            && 4 * mag(h[0]) <= 5 * h[3] && 4 * mag(h[1]) <= 5 * h[3];
        o.cx = 32'(h[0]); o.cy = 32'(h[1]); o.cz = 32'(h[2]); o.cw = 32'(h[3]);
        o.px = 32'(pr[0]); o.py = 32'(pr[1]); o.pz = 32'(pr[2]);
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0d] %s: got %h, expected %h", cycles, what, got, want);
        mismatches++;
    endtask

    // Result side: random stalls, each word compared with the oldest expectation.
    initial begin
        vertex_out_t got, want;
        int stall;
        wait (aresetn);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            repeat (stall) @(negedge aclk) m_tready <= 0;
            @(negedge aclk) m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
            got.cx = m_tdata[31:0];    got.cy = m_tdata[63:32];
            got.cz = m_tdata[95:64];   got.cw = m_tdata[127:96];
            got.px = m_tdata[159:128]; got.py = m_tdata[191:160];
            got.pz = m_tdata[223:192];
            got.wz = m_tuser[0];       got.vis = m_tuser[1];
            words_out++;
            if (pending_vertices.size() == 0) begin
                report_mismatch("unexpected word", got.cx, '0);
                continue;
            end
            want = pending_vertices.pop_front();
            visible_seen += want.vis;
            wzero_seen += want.wz;
            if (got.cx !== want.cx) report_mismatch("clip_x", got.cx, want.cx);
            if (got.cy !== want.cy) report_mismatch("clip_y", got.cy, want.cy);
            if (got.cz !== want.cz) report_mismatch("clip_z", got.cz, want.cz);
            if (got.cw !== want.cw) report_mismatch("clip_w", got.cw, want.cw);
            if (got.px !== want.px) report_mismatch("proj_x", got.px, want.px);
            if (got.py !== want.py) report_mismatch("proj_y", got.py, want.py);
            if (got.pz !== want.pz) report_mismatch("proj_z", got.pz, want.pz);
            if (got.wz !== want.wz)
                report_mismatch("w_zero", 32'(got.wz), 32'(want.wz));
            if (got.vis !== want.vis)
                report_mismatch("visible", 32'(got.vis), 32'(want.vis));
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < NUM_REGS) matrix[idx] = val;
        @(negedge aclk) cfg_valid <= 0;
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              bit known, vertex_out_t want);
        vertex_out_t predicted;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        repeat (gap) @(negedge aclk) s_tvalid <= 0;
        @(negedge aclk);
        s_tvalid <= 1;
        s_tdata <= {z, y, x};
        do @(posedge aclk); while (!s_tready);
        predicted = transform_vertex(x, y, z);
        if (known && predicted !== want)
            report_mismatch("predictor vs table", predicted.cx, want.cx);
        pending_vertices.push_back(known ? want : predicted);
    endtask

    task automatic drain;
        @(negedge aclk) s_tvalid <= 0;
        wait (pending_vertices.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_coord(int shape);
        case (shape)
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'(signed'($urandom_range(0, 2 * 8 * 65536)) - 8 * 65536);
        endcase
    endfunction

    function automatic logic [63:0] random_reg(int shape);
        logic [31:0] a, b;
        a = random_coord(shape);
        b = random_coord(shape);
        if (shape >= 2) begin
            a = 32'(signed'(a) >>> 2);
            b = 32'(signed'(b) >>> 2);
        end
        return {b, a};
    endfunction

    initial begin
        point_row_t rows [$];
        point_row_t row;
        vertex_out_t w;
        int shape;

        for (int i = 0; i < NUM_REGS; i++) matrix[i] = MAT_RESET[i];
        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1;

        // Identity: origin maps to itself and is visible.
        row = '{32'h0, 32'h0, 32'h0, 1'b1, '0};
        row.want = '{cx: 0, cy: 0, cz: 0, cw: 32'h0001_0000, px: 0, py: 0, pz: 0,
                     wz: 0, vis: 1};
        rows.push_back(row);
        row = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b1, '0};
        row.want = '{cx: 32'h7FFF_FFFF, cy: 32'h8000_0000, cz: 32'h0001_0000,
                     cw: 32'h0001_0000, px: 32'h7FFF_FFFF, py: 32'h8000_0000,
                     pz: 32'h0001_0000, wz: 0, vis: 0};
        rows.push_back(row);
        row = '{32'h0001_4000, 32'hFFFE_C000, 32'h0001_8000, 1'b1, '0};
        row.want = '{cx: 32'h0001_4000, cy: 32'hFFFE_C000, cz: 32'h0001_8000,
                     cw: 32'h0001_0000, px: 32'h0001_4000, py: 32'hFFFE_C000,
                     pz: 32'h0001_8000, wz: 0, vis: 1};
        rows.push_back(row);
        rows.push_back('{32'h0001_4001, 32'h0, 32'h0, 1'b0, '0});
        rows.push_back('{32'h0, 32'h0, 32'hFFFE_7FFF, 1'b0, '0});
        rows.push_back('{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b0, '0});
        foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z,
                                     rows[i].known, rows[i].want);
        drain();

        // Perspective-style matrix: w taken from z, so w can be zero or negative.
        write_reg(REG_C0R01, 64'h0000_0000_0001_0000);
        write_reg(REG_C1R01, 64'h0001_0000_0000_0000);
        write_reg(REG_C2R23, 64'h0001_0000_0000_8000);
        write_reg(REG_C3R23, 64'h0000_0000_0000_0000);
        write_reg(REG_C0R23, 64'h0);
        write_reg(REG_C1R23, 64'h0);
        write_reg(REG_C2R01, 64'h0);
        write_reg(REG_C3R01, 64'h0);
        write_reg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_point(32'h0, 32'h0, 32'h0, 0, w);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0, 0, w);
        send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000, 0, w);
        send_point(32'h0003_0000, 32'h0, 32'h0001_0000, 0, w);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 0, w);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, w);
        send_point(32'h0001_0000, 32'h0, 32'hFFFF_0000, 0, w);
        drain();

        // Extreme coefficients to force saturation.
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(REG_C0R01 + CFG_IDX_W'(i), (i % 2) ? 64'h8000_0000_7FFF_FFFF
                                                         : 64'h7FFF_FFFF_8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, w);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, w);
        send_point(32'h0, 32'h0, 32'h0, 0, w);
        send_point(32'hFFFF_FFFF, 32'h0, 32'h1, 0, w);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            shape = (ph < 2) ? ph : 2;
            for (int i = 0; i < NUM_REGS; i++)
                write_reg(REG_C0R01 + CFG_IDX_W'(i), random_reg(shape));
            // Mostly a sane w row so divides and visibility get exercised.
            if (ph >= 3) begin
                write_reg(REG_C3R23, {32'(signed'($urandom_range(0, 8 * 65536)) - 65536),
                                      random_coord(2)});
                write_reg(REG_C2R23, {32'(signed'($urandom_range(0, 65536)) - 32768),
                                      random_coord(2)});
            end
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_NONE + CFG_IDX_W'($urandom_range(0, 200)), 64'($urandom()));
            for (int n = 0; n < RANDOM_POINTS / 10; n++)
                send_point(random_coord($urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : 2),
                           random_coord($urandom_range(0, 9) == 0 ? 0 : 2),
                           random_coord($urandom_range(0, 9) == 0 ? 1 : 2), 0, w);
            drain();
        end

        $display("Checked %0d vertices over directed and ten random matrix settings.",
                 words_out);
        $display("Of these %0d were visible and %0d had zero w.", visible_seen, wzero_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> vertex_transform_clip_test_top.f
rtl/core/vtct_pkg.sv
rtl/core/vtct_xform.sv
rtl/core/vtct_div.sv
rtl/core/vertex_transform_clip_test_top.sv
rtl/core/vtct_check.sv
tb/vertex_transform_clip_test_top_tb.sv
